>>> rtl/core/assert_macros.svh
// assert_macros.svh: assertion macros used by the vector unit RTL.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define VAU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("vector unit assertion failed");

// Next-cycle implication, checked out of reset
`define VAU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("vector unit assertion failed");

`endif

>>> rtl/core/vau_pkg.sv
// vau_pkg: types, codes and pipeline sizes of the 2D vector unit.
// No dependencies; used by every module in rtl/core.
package vau_pkg;

    // Command codes
    localparam logic [2:0] CMD_ADD  = 3'd0;
    localparam logic [2:0] CMD_SUB  = 3'd1;
    localparam logic [2:0] CMD_SCL  = 3'd2;
    localparam logic [2:0] CMD_LEN  = 3'd3;
    localparam logic [2:0] CMD_NORM = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    // Pipeline shape: two front stages, one root bit per cell, one quotient bit per cell
    localparam int SQRT_CELLS = 32;
    localparam int DIV_CELLS  = 17;
    localparam int DEPTH      = 2 + SQRT_CELLS + DIV_CELLS;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
    } in_t;

    typedef struct packed {
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic [30:0]        magnitude;
        logic [1:0]         status;
    } out_t;

    // Square root cell state
    typedef struct packed {
        logic [63:0] rad;
        logic [35:0] rem;
        logic [31:0] root;
    } sqrt_t;

    // Divider cell state, both lanes share the divisor
    typedef struct packed {
        logic [31:0] den;
        logic [16:0] num_x;
        logic [16:0] num_y;
        logic [32:0] rem_x;
        logic [32:0] rem_y;
        logic [16:0] quo_x;
        logic [16:0] quo_y;
    } div_t;

    // Side data that rides along the pipeline
    typedef struct packed {
        logic [2:0]         cmd;
        logic               neg_x;
        logic               neg_y;
        logic [31:0]        ux;
        logic [31:0]        uy;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic               sat;
    } side_t;

endpackage

>>> rtl/core/vector2_arith_unit.sv
// vector2_arith_unit: 2D Q16.16 vector unit (add, subtract, scale, length, normalize).
// One request per cycle unless the row stalls. A request passes through two front
// stages (multipliers, then sum of squares and scale rounding), a row of 32 square root
// cells giving one root bit each, and a row of 17 divider cells giving one quotient bit
// each. The whole row stalls only when the output register and its skid stage are both
// full. Depends on vau_pkg, vau_sqrt_cell, vau_div_cell and assert_macros.svh.
`include "assert_macros.svh"

module vector2_arith_unit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  vau_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output vau_pkg::out_t m_data
);

    localparam int LAST = vau_pkg::DEPTH - 1;

    logic en;
    logic valid_reg [0:LAST];
    vau_pkg::side_t side_reg [0:LAST];
    vau_pkg::side_t side0_next;
    vau_pkg::side_t side1_next;

    logic signed [63:0] px_reg;
    logic signed [63:0] py_reg;
    logic [63:0]        sqx_reg;
    logic [63:0]        sqy_reg;
    logic [63:0]        sum_reg;

    logic signed [32:0] ex;
    logic signed [32:0] ey;
    logic signed [63:0] qx;
    logic signed [63:0] qy;

    vau_pkg::sqrt_t sq_stage [0:vau_pkg::SQRT_CELLS];
    vau_pkg::div_t  dv_stage [0:vau_pkg::DIV_CELLS];

    vau_pkg::out_t res;
    logic [31:0]   len;
    logic [31:0]   qxe;
    logic [31:0]   qye;
    logic          fsat;

    vau_pkg::out_t out_reg;
    vau_pkg::out_t out_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    vau_pkg::out_t skid_reg;
    vau_pkg::out_t skid_next;
    logic          skid_valid_reg;
    logic          skid_valid_next;

    assign en      = !skid_valid_reg;
    assign s_ready = en;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Front stage: add or subtract with saturation, magnitudes and signs
    always_comb begin
        side0_next       = '0;
        side0_next.cmd   = s_data.command;
        side0_next.neg_x = s_data.a_x[31];
        side0_next.neg_y = s_data.a_y[31];
        side0_next.ux    = s_data.a_x[31] ? (32'd0 - s_data.a_x) : s_data.a_x;
        side0_next.uy    = s_data.a_y[31] ? (32'd0 - s_data.a_y) : s_data.a_y;
        ex = '0;
        ey = '0;
        case (s_data.command)
            vau_pkg::CMD_ADD: begin
                ex = 33'(s_data.a_x) + 33'(s_data.b_x);
                ey = 33'(s_data.a_y) + 33'(s_data.b_y);
            end
            vau_pkg::CMD_SUB: begin
                ex = 33'(s_data.a_x) - 33'(s_data.b_x);
                ey = 33'(s_data.a_y) - 33'(s_data.b_y);
            end
            default: begin
                ex = '0;
                ey = '0;
            end
        endcase
        side0_next.rx = (ex[32] != ex[31]) ? {ex[32], {31{!ex[32]}}} : ex[31:0];
        side0_next.ry = (ey[32] != ey[31]) ? {ey[32], {31{!ey[32]}}} : ey[31:0];
        side0_next.sat = (ex[32] != ex[31]) || (ey[32] != ey[31]);
    end

    // Second stage: round scale products to nearest and saturate
    always_comb begin
        side1_next = side_reg[0];
        qx = px_reg + 64'sd32768;
        qy = py_reg + 64'sd32768;
        if (side_reg[0].cmd == vau_pkg::CMD_SCL) begin
            if ((&qx[63:47]) || !(|qx[63:47])) begin
                side1_next.rx = qx[47:16];
            end else begin
                side1_next.rx = {qx[63], {31{!qx[63]}}};
                side1_next.sat = 1'b1;
            end
            if ((&qy[63:47]) || !(|qy[63:47])) begin
                side1_next.ry = qy[47:16];
            end else begin
                side1_next.ry = {qy[63], {31{!qy[63]}}};
                side1_next.sat = 1'b1;
            end
        end
    end

    // Hold front stage data paths
    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg  <= 64'(s_data.a_x) * 64'(s_data.b_x);
            py_reg  <= 64'(s_data.a_y) * 64'(s_data.b_x);
            sqx_reg <= {32'd0, side0_next.ux} * {32'd0, side0_next.ux};
            sqy_reg <= {32'd0, side0_next.uy} * {32'd0, side0_next.uy};
            sum_reg <= sqx_reg + sqy_reg;
            side_reg[0] <= side0_next;
            side_reg[1] <= side1_next;
            for (int i = 2; i <= LAST; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Advance valid bits along the row
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= LAST; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= s_valid;
            for (int i = 1; i <= LAST; i++) begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // Square root row
    assign sq_stage[0] = '{rad: sum_reg, rem: 36'd0, root: 32'd0};

    for (genvar k = 0; k < vau_pkg::SQRT_CELLS; k++) begin : g_sqrt
        vau_sqrt_cell u_cell (
            .aclk     (aclk),
            .en       (en),
            .cell_in  (sq_stage[k]),
            .cell_out (sq_stage[k+1])
        );
    end

    // Divider row: numerator is |a| * 2^16, top 31 bits start as remainder
    always_comb begin
        dv_stage[0].den   = sq_stage[vau_pkg::SQRT_CELLS].root;
        dv_stage[0].num_x = {side_reg[vau_pkg::SQRT_CELLS + 1].ux[0], 16'd0};
        dv_stage[0].num_y = {side_reg[vau_pkg::SQRT_CELLS + 1].uy[0], 16'd0};
        dv_stage[0].rem_x = {2'b00, side_reg[vau_pkg::SQRT_CELLS + 1].ux[31:1]};
        dv_stage[0].rem_y = {2'b00, side_reg[vau_pkg::SQRT_CELLS + 1].uy[31:1]};
        dv_stage[0].quo_x = '0;
        dv_stage[0].quo_y = '0;
    end

    for (genvar j = 0; j < vau_pkg::DIV_CELLS; j++) begin : g_div
        vau_div_cell u_cell (
            .aclk     (aclk),
            .en       (en),
            .cell_in  (dv_stage[j]),
            .cell_out (dv_stage[j+1])
        );
    end

    // Final result assembly
    always_comb begin
        len  = dv_stage[vau_pkg::DIV_CELLS].den;
        qxe  = {15'd0, dv_stage[vau_pkg::DIV_CELLS].quo_x};
        qye  = {15'd0, dv_stage[vau_pkg::DIV_CELLS].quo_y};
        fsat = side_reg[LAST].sat;
        res  = '0;
        case (side_reg[LAST].cmd)
            vau_pkg::CMD_ADD, vau_pkg::CMD_SUB, vau_pkg::CMD_SCL: begin
                res.r_x = side_reg[LAST].rx;
                res.r_y = side_reg[LAST].ry;
            end
            vau_pkg::CMD_LEN, vau_pkg::CMD_NORM: begin
                if (side_reg[LAST].cmd == vau_pkg::CMD_NORM && len == 32'd0) begin
                    fsat = 1'b0;
                end else begin
                    res.magnitude = len[31] ? 31'h7FFF_FFFF : len[30:0];
                    fsat = len[31];
                    if (side_reg[LAST].cmd == vau_pkg::CMD_NORM) begin
                        res.r_x = side_reg[LAST].neg_x ? (32'd0 - qxe) : qxe;
                        res.r_y = side_reg[LAST].neg_y ? (32'd0 - qye) : qye;
                    end
                end
            end
            default: begin
                fsat = 1'b0;
            end
        endcase
        if (side_reg[LAST].cmd == vau_pkg::CMD_NORM && len == 32'd0) begin
            res.status = vau_pkg::ST_ZERO;
        end else if (fsat) begin
            res.status = vau_pkg::ST_SAT;
        end else begin
            res.status = vau_pkg::ST_OK;
        end
    end

    // Output register with skid stage
    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (en) begin
            if (!out_valid_reg || m_ready) begin
                out_next       = res;
                out_valid_next = valid_reg[LAST];
            end else if (valid_reg[LAST]) begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end else if (m_ready) begin
            out_next        = skid_reg;
            skid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    `VAU_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `VAU_ASSERT_NXT(a_skid_drains, skid_valid_reg && m_ready, !skid_valid_reg)
    `VAU_ASSERT_IMP(a_zero_vec_clean, m_valid && m_data.status == vau_pkg::ST_ZERO, m_data.magnitude == 31'd0 && m_data.r_x == 32'sd0 && m_data.r_y == 32'sd0)

endmodule

>>> rtl/core/vau_sqrt_cell.sv
// vau_sqrt_cell: one restoring square root step, yields one root bit.
// Depends on vau_pkg.
module vau_sqrt_cell (
    input  logic           aclk,
    input  logic           en,
    input  vau_pkg::sqrt_t cell_in,
    output vau_pkg::sqrt_t cell_out
);

    logic [35:0] r2;
    logic [35:0] trial;
    logic        ge;
    vau_pkg::sqrt_t cell_next;

    // Bring down two radicand bits and try the next root bit
    always_comb begin
        r2    = {cell_in.rem[33:0], cell_in.rad[63:62]};
        trial = {2'b00, cell_in.root, 2'b01};
        ge    = (r2 >= trial);
        cell_next.rad  = {cell_in.rad[61:0], 2'b00};
        cell_next.rem  = ge ? (r2 - trial) : r2;
        cell_next.root = {cell_in.root[30:0], ge};
    end

    // Advance when the pipeline moves
    always_ff @(posedge aclk) begin
        if (en) begin
            cell_out <= cell_next;
        end
    end

endmodule

>>> rtl/core/vau_div_cell.sv
// vau_div_cell: one restoring division step for both lanes, one quotient bit each.
// Depends on vau_pkg.
module vau_div_cell (
    input  logic          aclk,
    input  logic          en,
    input  vau_pkg::div_t cell_in,
    output vau_pkg::div_t cell_out
);

    logic [32:0] rx;
    logic [32:0] ry;
    logic [32:0] dd;
    logic        gx;
    logic        gy;
    vau_pkg::div_t cell_next;

    // Shift in the next numerator bit and subtract the divisor where it fits
    always_comb begin
        dd = {1'b0, cell_in.den};
        rx = {cell_in.rem_x[31:0], cell_in.num_x[16]};
        ry = {cell_in.rem_y[31:0], cell_in.num_y[16]};
        gx = (rx >= dd);
        gy = (ry >= dd);
        cell_next.den   = cell_in.den;
        cell_next.num_x = {cell_in.num_x[15:0], 1'b0};
        cell_next.num_y = {cell_in.num_y[15:0], 1'b0};
        cell_next.rem_x = gx ? (rx - dd) : rx;
        cell_next.rem_y = gy ? (ry - dd) : ry;
        cell_next.quo_x = {cell_in.quo_x[15:0], gx};
        cell_next.quo_y = {cell_in.quo_y[15:0], gy};
    end

    // Advance when the pipeline moves
    always_ff @(posedge aclk) begin
        if (en) begin
            cell_out <= cell_next;
        end
    end

endmodule

>>> bench/tb_top.sv
// tb_top: self-checking bench for vector2_arith_unit (add, subtract, scale, length, normalize).
// Depends on vau_pkg and the vector2_arith_unit RTL; random stimulus with randomized idling.
`timescale 1ns / 1ps

module tb_top;

    logic          aclk;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    vau_pkg::in_t  s_data;
    logic          m_valid;
    logic          m_ready;
    vau_pkg::out_t m_data;
    logic          s_ready_seen;

    vau_pkg::in_t  pending_q[$];
    vau_pkg::out_t expected_q[$];
    int    sent_cnt;
    int    recv_cnt;
    int    mismatch_cnt;
    int    send_idle_pct;
    int    recv_stall_pct;

    vector2_arith_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 12 ns clock
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Integer floor square root of a 64-bit value, one bit per pass
    function automatic logic [63:0] floor_root(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Clamp to signed 32 bits and flag saturation
    function automatic logic signed [31:0] clamp32(longint v, inout bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Round-half-up Q16.16 product, then clamp
    function automatic logic signed [31:0] scaled(longint a, longint s, inout bit sat);
        longint p;
        p = a * s + 64'sd32768;
        return clamp32(p >>> 16, sat);
    endfunction

    // Truncating signed division of a component by the length
    function automatic logic signed [31:0] unit_comp(longint a, logic [63:0] len);
        logic [63:0] q;
        logic [63:0] mag;
        mag = (a < 0) ? -a : a;
        q   = (mag << 16) / len;
        return (a < 0) ? -q[31:0] : q[31:0];
    endfunction

    // Compute the expected result of one request
    function automatic vau_pkg::out_t vector_result(vau_pkg::in_t req);
        vau_pkg::out_t r;
        bit          sat;
        longint      ax;
        longint      ay;
        longint      bx;
        longint      by;
        logic [63:0] ux;
        logic [63:0] uy;
        logic [63:0] len;
        r   = '0;
        sat = 1'b0;
        ax  = req.a_x;
        ay  = req.a_y;
        bx  = req.b_x;
        by  = req.b_y;
        case (req.command)
            vau_pkg::CMD_ADD: begin
                r.r_x = clamp32(ax + bx, sat);
                r.r_y = clamp32(ay + by, sat);
            end
            vau_pkg::CMD_SUB: begin
                r.r_x = clamp32(ax - bx, sat);
                r.r_y = clamp32(ay - by, sat);
            end
            vau_pkg::CMD_SCL: begin
                r.r_x = scaled(ax, bx, sat);
                r.r_y = scaled(ay, bx, sat);
            end
            vau_pkg::CMD_LEN, vau_pkg::CMD_NORM: begin
                ux  = (ax < 0) ? -ax : ax;
                uy  = (ay < 0) ? -ay : ay;
                len = floor_root(ux * ux + uy * uy);
                if (req.command == vau_pkg::CMD_NORM && len == 0) begin
                    r.status = vau_pkg::ST_ZERO;
                end else begin
                    if (len > 64'h7FFFFFFF) begin
                        r.magnitude = 31'h7FFFFFFF;
                        sat = 1'b1;
                    end else begin
                        r.magnitude = len[30:0];
                    end
                    if (req.command == vau_pkg::CMD_NORM) begin
                        r.r_x = unit_comp(ax, len);
                        r.r_y = unit_comp(ay, len);
                    end
                end
            end
            default: ;
        endcase
        if (sat && r.status == vau_pkg::ST_OK) r.status = vau_pkg::ST_SAT;
        return r;
    endfunction

    // Random component, biased toward extremes and small values
    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 9))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 3) - 32'd1;
            3: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
            4: return 32'($urandom_range(0, 16'hFFFF)) << $urandom_range(0, 16);
            default: return $urandom;
        endcase
    endfunction

    function automatic vau_pkg::in_t make_req(logic [2:0] cmd, logic [31:0] ax,
                                              logic [31:0] ay, logic [31:0] bx,
                                              logic [31:0] by);
        vau_pkg::in_t r;
        r.command = cmd;
        r.a_x     = ax;
        r.a_y     = ay;
        r.b_x     = bx;
        r.b_y     = by;
        return r;
    endfunction

    // Driver: present the next pending request, hold it until accepted
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready_seen) begin
            if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_data  <= pending_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Acceptance flag sampled at the rising edge for the driver
    always @(posedge aclk) begin
        s_ready_seen <= s_valid && s_ready && aresetn;
    end

    // Monitor: predict on acceptance, check each delivered result
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_q.push_back(vector_result(s_data));
                sent_cnt++;
            end
            if (m_valid && m_ready) begin
                recv_cnt++;
                if (expected_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("ERROR: unexpected result %h", m_data);
                end else if (m_data !== expected_q[0]) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display({"ERROR: result %0d exp x=%h y=%h mag=%h st=%0d",
                                  " got x=%h y=%h mag=%h st=%0d"},
                                 recv_cnt, expected_q[0].r_x, expected_q[0].r_y,
                                 expected_q[0].magnitude, expected_q[0].status,
                                 m_data.r_x, m_data.r_y, m_data.magnitude, m_data.status);
                    void'(expected_q.pop_front());
                end else begin
                    void'(expected_q.pop_front());
                end
            end
        end
    end

    // Stimulus: directed corners, then random phases with varied idling
    initial begin
        s_valid        = 1'b0;
        s_data         = '0;
        m_ready        = 1'b0;
        s_ready_seen   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        sent_cnt       = 0;
        recv_cnt       = 0;
        mismatch_cnt   = 0;
        aresetn        = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed corners of every command
        pending_q.push_back(make_req(vau_pkg::CMD_ADD, 32'h7FFFFFFF, 32'h80000000,
                                     32'd1, 32'hFFFFFFFF));
        pending_q.push_back(make_req(vau_pkg::CMD_ADD, 32'h00010000, 32'hFFFF0000,
                                     32'h00020000, 32'd5));
        pending_q.push_back(make_req(vau_pkg::CMD_SUB, 32'h80000000, 32'h7FFFFFFF,
                                     32'd1, 32'hFFFFFFFF));
        pending_q.push_back(make_req(vau_pkg::CMD_SUB, 32'h12345678, 32'd0,
                                     32'h12345678, 32'd7));
        pending_q.push_back(make_req(vau_pkg::CMD_SCL, 32'h80000000, 32'h80000000,
                                     32'h80000000, 32'd0));
        pending_q.push_back(make_req(vau_pkg::CMD_SCL, 32'h00018000, 32'hFFFE8000,
                                     32'h00008000, 32'hFFFFFFFF));
        pending_q.push_back(make_req(vau_pkg::CMD_SCL, 32'd1, 32'hFFFFFFFF,
                                     32'h00008000, 32'd0));
        pending_q.push_back(make_req(vau_pkg::CMD_SCL, 32'h7FFFFFFF, 32'd3,
                                     32'h00010000, 32'd0));
        pending_q.push_back(make_req(vau_pkg::CMD_LEN, 32'h80000000, 32'h80000000,
                                     32'd0, 32'd0));
        pending_q.push_back(make_req(vau_pkg::CMD_LEN, 32'h00030000, 32'hFFFC0000,
                                     32'd9, 32'd9));
        pending_q.push_back(make_req(vau_pkg::CMD_LEN, 32'd0, 32'd0,
                                     32'hFFFFFFFF, 32'hFFFFFFFF));
        pending_q.push_back(make_req(vau_pkg::CMD_LEN, 32'h7FFFFFFF, 32'd0,
                                     32'd0, 32'd0));
        pending_q.push_back(make_req(vau_pkg::CMD_NORM, 32'd0, 32'd0, 32'd1, 32'd1));
        pending_q.push_back(make_req(vau_pkg::CMD_NORM, 32'h80000000, 32'h80000000,
                                     32'd0, 32'd0));
        pending_q.push_back(make_req(vau_pkg::CMD_NORM, 32'd1, 32'd0, 32'd0, 32'd0));
        pending_q.push_back(make_req(vau_pkg::CMD_NORM, 32'hFFFD0000, 32'h00040000,
                                     32'd0, 32'd0));
        pending_q.push_back(make_req(vau_pkg::CMD_NORM, 32'h7FFFFFFF, 32'h80000000,
                                     32'd0, 32'd0));
        pending_q.push_back(make_req(3'd5, 32'h7FFFFFFF, 32'd1, 32'd2, 32'd3));
        pending_q.push_back(make_req(3'd6, 32'hFFFFFFFF, 32'hFFFFFFFF,
                                     32'hFFFFFFFF, 32'hFFFFFFFF));
        pending_q.push_back(make_req(3'd7, 32'h80000000, 32'd0, 32'd0, 32'd0));

        // Random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 63 : (ph == 3) ? 14 : 0;
            recv_stall_pct = (ph == 2) ? 63 : (ph == 3) ? 14 : 0;
            for (int i = 0; i < 360; i++) begin
                pending_q.push_back(make_req($urandom_range(0, 9) == 0 ?
                                             3'($urandom_range(5, 7)) :
                                             3'($urandom_range(0, 4)),
                                             rand_comp(), rand_comp(),
                                             rand_comp(), rand_comp()));
            end
            wait (pending_q.size() == 0);
        end
        @(posedge aclk);
        wait (!s_valid);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait (expected_q.size() == 0);
        repeat (60) @(posedge aclk);

        $display("Covered %0d requests over all five commands and undefined codes,", sent_cnt);
        $display("with sender idling and receiver stalls in four phases; %0d results checked.",
                 recv_cnt);
        if (mismatch_cnt == 0 && expected_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> vector2_arith_unit.f
+incdir+rtl/core
rtl/core/vau_pkg.sv
rtl/core/vau_sqrt_cell.sv
rtl/core/vau_div_cell.sv
rtl/core/vector2_arith_unit.sv
bench/tb_top.sv
